@@ hdl/sssb_pkg.sv @@
// shared types, constants and helpers for the shelf strip bounds block
// no dependencies
package sssb_pkg;

	localparam logic [15:0] MinLen   = 16'd655;
	localparam logic [12:0] ExtraLen = 13'd6554;

	localparam logic [21:0] DepthRst = 22'd19661;
	localparam logic [21:0] TrimRst  = 22'd65536;
	localparam logic [15:0] ThrRst   = 16'd655;

	typedef enum logic [1:0] {
		REG_DEPTH = 2'd0,
		REG_TRIM  = 2'd1,
		REG_THR   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_z;
		logic [21:0]        aisle_width;
		logic [21:0]        left_protrusion;
		logic [21:0]        right_protrusion;
	} seg_t;

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_z;
		logic               shelf_side;
		logic               last_box;
	} box_t;

	// segment data that rides alongside the root and divider
	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sz;
		logic signed [31:0] ex;
		logic signed [31:0] ez;
		logic [21:0]        width;
		logic [32:0]        ax;
		logic [32:0]        az;
		logic               sgx;
		logic               sgz;
		logic               sh;
		logic               want_l;
		logic               want_r;
	} side_t;

	typedef struct packed {
		logic signed [31:0] mnx;
		logic signed [31:0] mnz;
		logic signed [31:0] mxx;
		logic signed [31:0] mxz;
	} coords_t;

	typedef struct packed {
		logic    want_l;
		logic    want_r;
		coords_t lb;
		coords_t rb;
	} pair_t;

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		if (v > 37'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -37'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

@@ hdl/sssb_sqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on sssb_pkg
module sssb_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_v,
	input  logic [63:0]     rad_in,
	input  sssb_pkg::side_t side_in,
	output logic            out_v,
	output logic [31:0]     root_out,
	output sssb_pkg::side_t side_out
);
	import sssb_pkg::*;

	localparam int Steps = 32;

	logic        v_s    [Steps];
	logic [63:0] rad_s  [Steps];
	logic [33:0] rem_s  [Steps];
	logic [31:0] root_s [Steps];
	side_t       side_s [Steps];

	logic        v_n    [Steps];
	logic [63:0] rad_n  [Steps];
	logic [33:0] rem_n  [Steps];
	logic [31:0] root_n [Steps];
	side_t       side_n [Steps];

	always_comb begin
		logic [63:0] rad_i;
		logic [33:0] rem_i;
		logic [31:0] root_i;
		logic [35:0] cur;
		logic [35:0] trial;
		for (int i = 0; i < Steps; i++) begin
			if (i == 0) begin
				v_n[i]    = in_v;
				side_n[i] = side_in;
				rad_i     = rad_in;
				rem_i     = '0;
				root_i    = '0;
			end else begin
				v_n[i]    = v_s[i-1];
				side_n[i] = side_s[i-1];
				rad_i     = rad_s[i-1];
				rem_i     = rem_s[i-1];
				root_i    = root_s[i-1];
			end
			cur      = {rem_i, rad_i[63:62]};
			trial    = {2'b00, root_i, 2'b01};
			rad_n[i] = {rad_i[61:0], 2'b00};
			if (cur >= trial) begin
				rem_n[i]  = 34'(cur - trial);
				root_n[i] = {root_i[30:0], 1'b1};
			end else begin
				rem_n[i]  = cur[33:0];
				root_n[i] = {root_i[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Steps; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			for (int i = 0; i < Steps; i++) v_s[i] <= v_n[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < Steps; i++) begin
				rad_s[i]  <= rad_n[i];
				rem_s[i]  <= rem_n[i];
				root_s[i] <= root_n[i];
				side_s[i] <= side_n[i];
			end
		end
	end

	assign out_v    = v_s[Steps-1];
	assign root_out = root_s[Steps-1];
	assign side_out = side_s[Steps-1];

endmodule

@@ hdl/sssb_div.sv @@
// pipelined restoring divider, two lanes (x and z) sharing the divisor
// depends on sssb_pkg
module sssb_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_v,
	input  logic [32:0]     len,
	input  sssb_pkg::side_t side_in,
	output logic            out_v,
	output logic [30:0]     qx,
	output logic [30:0]     qz,
	output sssb_pkg::side_t side_out
);
	import sssb_pkg::*;

	localparam int Steps = 31;

	logic        v_s    [Steps];
	logic [32:0] len_s  [Steps];
	logic [32:0] remx_s [Steps];
	logic [32:0] remz_s [Steps];
	logic [30:0] qx_s   [Steps];
	logic [30:0] qz_s   [Steps];
	side_t       side_s [Steps];

	logic        v_n    [Steps];
	logic [32:0] len_n  [Steps];
	logic [32:0] remx_n [Steps];
	logic [32:0] remz_n [Steps];
	logic [30:0] qx_n   [Steps];
	logic [30:0] qz_n   [Steps];
	side_t       side_n [Steps];

	// quotient is (a << 30) / len; only the low bit of a is brought in after the start
	always_comb begin
		logic [32:0] rx, rz, dv;
		logic [30:0] ox, oz;
		logic        bx, bz;
		logic [33:0] cx, cz;
		for (int i = 0; i < Steps; i++) begin
			if (i == 0) begin
				v_n[i]    = in_v;
				side_n[i] = side_in;
				dv        = len;
				rx        = {1'b0, side_in.ax[32:1]};
				rz        = {1'b0, side_in.az[32:1]};
				ox        = '0;
				oz        = '0;
				bx        = side_in.ax[0];
				bz        = side_in.az[0];
			end else begin
				v_n[i]    = v_s[i-1];
				side_n[i] = side_s[i-1];
				dv        = len_s[i-1];
				rx        = remx_s[i-1];
				rz        = remz_s[i-1];
				ox        = qx_s[i-1];
				oz        = qz_s[i-1];
				bx        = 1'b0;
				bz        = 1'b0;
			end
			len_n[i] = dv;
			cx = {rx, bx};
			cz = {rz, bz};
			if (cx >= {1'b0, dv}) begin
				remx_n[i] = 33'(cx - {1'b0, dv});
				qx_n[i]   = {ox[29:0], 1'b1};
			end else begin
				remx_n[i] = cx[32:0];
				qx_n[i]   = {ox[29:0], 1'b0};
			end
			if (cz >= {1'b0, dv}) begin
				remz_n[i] = 33'(cz - {1'b0, dv});
				qz_n[i]   = {oz[29:0], 1'b1};
			end else begin
				remz_n[i] = cz[32:0];
				qz_n[i]   = {oz[29:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Steps; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			for (int i = 0; i < Steps; i++) v_s[i] <= v_n[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < Steps; i++) begin
				len_s[i]  <= len_n[i];
				remx_s[i] <= remx_n[i];
				remz_s[i] <= remz_n[i];
				qx_s[i]   <= qx_n[i];
				qz_s[i]   <= qz_n[i];
				side_s[i] <= side_n[i];
			end
		end
	end

	assign out_v    = v_s[Steps-1];
	assign qx       = qx_s[Steps-1];
	assign qz       = qz_s[Steps-1];
	assign side_out = side_s[Steps-1];

endmodule

@@ hdl/sssb_box.sv @@
// strip box stages: scale products, rounding and trimmed ends, extents, saturated corners
// depends on sssb_pkg
module sssb_box (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_v,
	input  logic [30:0]     qx,
	input  logic [30:0]     qz,
	input  sssb_pkg::side_t side_in,
	input  logic [21:0]     depth,
	input  logic [21:0]     trim,
	output logic            out_v,
	output sssb_pkg::pair_t pair
);
	import sssb_pkg::*;

	// stage 1: products on magnitudes
	logic        v_s1, v_s2, v_s3, v_s4;
	side_t       sd_s1;
	logic [52:0] tx_s1, tz_s1;
	logic [54:0] ix_s1, iz_s1, ox_s1, oz_s1;
	logic [23:0] outer2;

	assign outer2 = 24'(side_in.width) + {1'b0, depth, 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1 <= side_in;
			tx_s1 <= 53'(qx) * 53'(trim);
			tz_s1 <= 53'(qz) * 53'(trim);
			ix_s1 <= 55'(qz) * 55'(side_in.width);
			iz_s1 <= 55'(qx) * 55'(side_in.width);
			ox_s1 <= 55'(qz) * 55'(outer2);
			oz_s1 <= 55'(qx) * 55'(outer2);
		end
	end

	// stage 2: round half away from zero, apply signs, trimmed ends
	logic [23:0]        tmx, tmz;
	logic [24:0]        ixm, izm, oxm, ozm;
	logic signed [24:0] trx, trz;
	logic signed [34:0] tsx_s2, tsz_s2, tex_s2, tez_s2;
	logic signed [25:0] lix_s2, liz_s2, lox_s2, loz_s2;
	logic               wl_s2, wr_s2;

	assign tmx = 24'((54'({1'b0, tx_s1}) + (54'd1 << 29)) >> 30);
	assign tmz = 24'((54'({1'b0, tz_s1}) + (54'd1 << 29)) >> 30);
	assign ixm = 25'((56'({1'b0, ix_s1}) + (56'd1 << 30)) >> 31);
	assign izm = 25'((56'({1'b0, iz_s1}) + (56'd1 << 30)) >> 31);
	assign oxm = 25'((56'({1'b0, ox_s1}) + (56'd1 << 30)) >> 31);
	assign ozm = 25'((56'({1'b0, oz_s1}) + (56'd1 << 30)) >> 31);
	assign trx = sd_s1.sgx ? -$signed({1'b0, tmx}) : $signed({1'b0, tmx});
	assign trz = sd_s1.sgz ? -$signed({1'b0, tmz}) : $signed({1'b0, tmz});

	always_ff @(posedge clk) begin
		if (adv) begin
			tsx_s2 <= 35'(sd_s1.sx) + 35'(trx);
			tsz_s2 <= 35'(sd_s1.sz) + 35'(trz);
			tex_s2 <= 35'(sd_s1.ex) - 35'(trx);
			tez_s2 <= 35'(sd_s1.ez) - 35'(trz);
			// left perpendicular is (-dir_z, dir_x)
			lix_s2 <= sd_s1.sgz ? $signed({1'b0, ixm}) : -$signed({1'b0, ixm});
			lox_s2 <= sd_s1.sgz ? $signed({1'b0, oxm}) : -$signed({1'b0, oxm});
			liz_s2 <= sd_s1.sgx ? -$signed({1'b0, izm}) : $signed({1'b0, izm});
			loz_s2 <= sd_s1.sgx ? -$signed({1'b0, ozm}) : $signed({1'b0, ozm});
			wl_s2  <= sd_s1.want_l;
			wr_s2  <= sd_s1.want_r;
		end
	end

	// stage 3: extents of the ends and of the offsets; corners separate into sums
	logic signed [34:0] tnx_s3, tnz_s3, tmxx_s3, tmxz_s3;
	logic signed [25:0] onx_s3, onz_s3, omx_s3, omz_s3;
	logic               wl_s3, wr_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			tnx_s3  <= (tsx_s2 < tex_s2) ? tsx_s2 : tex_s2;
			tmxx_s3 <= (tsx_s2 > tex_s2) ? tsx_s2 : tex_s2;
			tnz_s3  <= (tsz_s2 < tez_s2) ? tsz_s2 : tez_s2;
			tmxz_s3 <= (tsz_s2 > tez_s2) ? tsz_s2 : tez_s2;
			onx_s3  <= (lix_s2 < lox_s2) ? lix_s2 : lox_s2;
			omx_s3  <= (lix_s2 > lox_s2) ? lix_s2 : lox_s2;
			onz_s3  <= (liz_s2 < loz_s2) ? liz_s2 : loz_s2;
			omz_s3  <= (liz_s2 > loz_s2) ? liz_s2 : loz_s2;
			wl_s3   <= wl_s2;
			wr_s3   <= wr_s2;
		end
	end

	// stage 4: corners with saturation, right side uses negated offsets
	pair_t pair_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s4.want_l <= wl_s3;
			pair_s4.want_r <= wr_s3;
			pair_s4.lb.mnx <= sat32(37'(tnx_s3) + 37'(onx_s3));
			pair_s4.lb.mxx <= sat32(37'(tmxx_s3) + 37'(omx_s3));
			pair_s4.lb.mnz <= sat32(37'(tnz_s3) + 37'(onz_s3));
			pair_s4.lb.mxz <= sat32(37'(tmxz_s3) + 37'(omz_s3));
			pair_s4.rb.mnx <= sat32(37'(tnx_s3) - 37'(omx_s3));
			pair_s4.rb.mxx <= sat32(37'(tmxx_s3) - 37'(onx_s3));
			pair_s4.rb.mnz <= sat32(37'(tnz_s3) - 37'(omz_s3));
			pair_s4.rb.mxz <= sat32(37'(tmxz_s3) - 37'(onz_s3));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_v = v_s4;
	assign pair  = pair_s4;

endmodule

@@ hdl/segment_shelf_strip_bounds_core.sv @@
// Shelf strip bounds: takes one aisle segment per word and gives zero, one or two
// strip boxes (left first). Fully pipelined: a segment word can be taken every cycle
// unless box_ready stalls the output or a second box is pending. Stages: 4 front stages,
// 32 root stages, 1 length check, 31 divider stages, 4 box stages, output register. A
// segment with both sides present holds the input until its second box has been moved
// into the output register. Configuration is written through cfg_we/cfg_index/cfg_data
// and takes effect on segments accepted afterwards; write only while idle.
// depends on sssb_pkg, sssb_sqrt, sssb_div, sssb_box
module segment_shelf_strip_bounds_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           seg_valid,
	output logic           seg_ready,
	input  sssb_pkg::seg_t seg,
	output logic           box_valid,
	input  logic           box_ready,
	output sssb_pkg::box_t box,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [21:0]    cfg_data
);
	import sssb_pkg::*;

	logic        adv;
	logic [21:0] depth_q, trim_q;
	logic [15:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DepthRst;
			trim_q  <= TrimRst;
			thr_q   <= ThrRst;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEPTH: depth_q <= cfg_data;
				REG_TRIM:  trim_q  <= cfg_data;
				REG_THR:   thr_q   <= cfg_data[15:0];
				default:   ;
			endcase
		end
	end

	// front stages: deltas, magnitudes, squares, sum
	logic               v_s1, v_s2, v_s3, v_s4;
	seg_t               seg_s1;
	logic signed [32:0] dx_s1, dz_s1;
	logic               wl_s1, wr_s1;
	side_t              sd_s2, sd_s3, sd_s4;
	logic [31:0]        axh, azh;
	logic [63:0]        sqx_s3, sqz_s3, rad_s4;
	logic [32:0]        axn, azn;

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1 <= seg;
			dx_s1  <= 33'(seg.end_x) - 33'(seg.start_x);
			dz_s1  <= 33'(seg.end_z) - 33'(seg.start_z);
			wl_s1  <= seg.left_protrusion > 22'(thr_q);
			wr_s1  <= seg.right_protrusion > 22'(thr_q);
		end
	end

	assign axn = dx_s1[32] ? 33'(~dx_s1 + 33'sd1) : dx_s1;
	assign azn = dz_s1[32] ? 33'(~dz_s1 + 33'sd1) : dz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2.sx     <= seg_s1.start_x;
			sd_s2.sz     <= seg_s1.start_z;
			sd_s2.ex     <= seg_s1.end_x;
			sd_s2.ez     <= seg_s1.end_z;
			sd_s2.width  <= seg_s1.aisle_width;
			sd_s2.ax     <= axn;
			sd_s2.az     <= azn;
			sd_s2.sgx    <= dx_s1[32];
			sd_s2.sgz    <= dz_s1[32];
			sd_s2.sh     <= axn[32] | axn[31] | azn[32] | azn[31];
			sd_s2.want_l <= wl_s1;
			sd_s2.want_r <= wr_s1;
		end
	end

	// huge deltas are halved before squaring, the root is doubled afterwards
	assign axh = sd_s2.sh ? sd_s2.ax[32:1] : sd_s2.ax[31:0];
	assign azh = sd_s2.sh ? sd_s2.az[32:1] : sd_s2.az[31:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s3  <= sd_s2;
			sqx_s3 <= 64'(axh) * 64'(axh);
			sqz_s3 <= 64'(azh) * 64'(azh);
			sd_s4  <= sd_s3;
			rad_s4 <= sqx_s3 + sqz_s3;
		end
	end

	logic        rt_v;
	logic [31:0] root;
	side_t       rt_sd;

	sssb_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s4),
		.rad_in   (rad_s4),
		.side_in  (sd_s4),
		.out_v    (rt_v),
		.root_out (root),
		.side_out (rt_sd)
	);

	// length check: too short, or nothing left after trimming
	logic        v_s5;
	logic [32:0] len_n, len_s5;
	logic        keep;
	side_t       sd_k;
	side_t       sd_s5;

	assign len_n = rt_sd.sh ? {root, 1'b0} : {1'b0, root};
	assign keep  = (len_n >= 33'(MinLen)) &&
		(len_n > 33'({1'b0, trim_q, 1'b0}) + 33'(ExtraLen));

	always_comb begin
		sd_k        = rt_sd;
		sd_k.want_l = rt_sd.want_l & keep;
		sd_k.want_r = rt_sd.want_r & keep;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s5 <= len_n;
			sd_s5  <= sd_k;
		end
	end

	logic        dv_v;
	logic [30:0] qx, qz;
	side_t       dv_sd;

	sssb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s5),
		.len      (len_s5),
		.side_in  (sd_s5),
		.out_v    (dv_v),
		.qx       (qx),
		.qz       (qz),
		.side_out (dv_sd)
	);

	logic  bx_v;
	pair_t pair;

	sssb_box u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (dv_v),
		.qx      (qx),
		.qz      (qz),
		.side_in (dv_sd),
		.depth   (depth_q),
		.trim    (trim_q),
		.out_v   (bx_v),
		.pair    (pair)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= seg_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= rt_v;
		end
	end

	// output register with a slot for the right box of a two-box segment
	logic out_v_q, pend_q, load;
	box_t out_q, pend_word_q, lw, rw;

	assign lw = '{box_min_x: pair.lb.mnx, box_min_z: pair.lb.mnz,
		box_max_x: pair.lb.mxx, box_max_z: pair.lb.mxz,
		shelf_side: 1'b0, last_box: !pair.want_r};
	assign rw = '{box_min_x: pair.rb.mnx, box_min_z: pair.rb.mnz,
		box_max_x: pair.rb.mxx, box_max_z: pair.rb.mxz,
		shelf_side: 1'b1, last_box: 1'b1};

	assign load = !out_v_q || box_ready;
	assign adv  = !pend_q && load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (pend_q) begin
			if (load) begin
				out_v_q <= 1'b1;
				pend_q  <= 1'b0;
			end
		end else if (adv) begin
			out_v_q <= bx_v && (pair.want_l || pair.want_r);
			pend_q  <= bx_v && pair.want_l && pair.want_r;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			if (load) out_q <= pend_word_q;
		end else if (adv) begin
			out_q       <= pair.want_l ? lw : rw;
			pend_word_q <= rw;
		end
	end

	assign seg_ready = adv;
	assign box_valid = out_v_q;
	assign box       = out_q;

endmodule

@@ hdl/sssb_chk.sv @@
// port-level checks for the shelf strip bounds block, bound to the top level
// depends on sssb_pkg and segment_shelf_strip_bounds_core
module sssb_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           seg_valid,
	input logic           seg_ready,
	input sssb_pkg::seg_t seg,
	input logic           box_valid,
	input logic           box_ready,
	input sssb_pkg::box_t box,
	input logic           cfg_we,
	input logic [1:0]     cfg_index,
	input logic [21:0]    cfg_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box_ready |=> box_valid && $stable(box))
		else $error("box word changed while stalled");

	a_left_first: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box.last_box |-> !box.shelf_side)
		else $error("non-final box is not the left side");

	a_right_last: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box.shelf_side |-> box.last_box)
		else $error("right box not marked last");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box_ready && !box.last_box |=>
		box_valid && box.shelf_side && box.last_box)
		else $error("right box did not follow the left one");

	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box.last_box |-> !seg_ready)
		else $error("segment taken while a second box is pending");

endmodule

bind segment_shelf_strip_bounds_core sssb_chk u_chk (.*);

@@ tb/tb_top.sv @@
// self-checking bench for segment_shelf_strip_bounds_core: directed and random segments
// checked box by box against a predictor of the strip bounds; depends on sssb_pkg
module tb_top;
	import sssb_pkg::*;

	typedef struct {
		seg_t s;
		bit   no_box;
	} seg_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_ready;
	seg_t seg = '0;
	logic box_valid;
	logic box_ready = 1'b0;
	box_t box;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [21:0] cfg_data = '0;

	logic [21:0] depth_q = DepthRst;
	logic [21:0] trim_q = TrimRst;
	logic [15:0] thr_q = ThrRst;

	box_t boxes_due[$];
	int   errors = 0;
	bit   quiet = 1'b0;
	bit   hold_req = 1'b0;

	segment_shelf_strip_bounds_core DUT (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
		.box_valid(box_valid), .box_ready(box_ready), .box(box),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// signed q30 times m, rounded half away from zero
	function automatic longint round_scale(input longint d, input longint unsigned m, input int sh);
		longint unsigned mag = (d < 0) ? longint'(-d) : d;
		longint unsigned r = (mag * m + (64'd1 << (sh - 1))) >> sh;
		return (d < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic int strip_boxes(input seg_t s, output box_t b[2]);
		longint dx, dz, dir_x, dir_z, trim_x, trim_z, ts_x, ts_z, te_x, te_z;
		longint px, pz, ix, iz, ox, oz, mnx, mnz, mxx, mxz;
		longint cx[4], cz[4];
		longint unsigned ax, az, len, inner2, outer2;
		int sh, n;
		bit want[2];
		n = 0;
		b[0] = '0;
		b[1] = '0;
		if (s.left_protrusion < thr_q && s.right_protrusion < thr_q)
			return 0;
		dx = longint'(s.end_x) - longint'(s.start_x);
		dz = longint'(s.end_z) - longint'(s.start_z);
		ax = (dx < 0) ? -dx : dx;
		az = (dz < 0) ? -dz : dz;
		sh = (ax >= 64'h80000000 || az >= 64'h80000000) ? 1 : 0;
		len = int_sqrt((ax >> sh) * (ax >> sh) + (az >> sh) * (az >> sh)) << sh;
		if (len < MinLen)
			return 0;
		dir_x = (ax << 30) / len;
		dir_z = (az << 30) / len;
		if (dx < 0) dir_x = -dir_x;
		if (dz < 0) dir_z = -dir_z;
		if (len <= 2 * longint'(trim_q) + ExtraLen)
			return 0;
		trim_x = round_scale(dir_x, trim_q, 30);
		trim_z = round_scale(dir_z, trim_q, 30);
		ts_x = longint'(s.start_x) + trim_x;
		ts_z = longint'(s.start_z) + trim_z;
		te_x = longint'(s.end_x) - trim_x;
		te_z = longint'(s.end_z) - trim_z;
		inner2 = s.aisle_width;
		outer2 = s.aisle_width + 2 * longint'(depth_q);
		want[0] = s.left_protrusion > thr_q;
		want[1] = s.right_protrusion > thr_q;
		for (int side = 0; side < 2; side++) begin
			if (want[side]) begin
				px = (side == 0) ? -dir_z : dir_z;
				pz = (side == 0) ? dir_x : -dir_x;
				ix = round_scale(px, inner2, 31);
				iz = round_scale(pz, inner2, 31);
				ox = round_scale(px, outer2, 31);
				oz = round_scale(pz, outer2, 31);
				cx[0] = ts_x + ix; cz[0] = ts_z + iz;
				cx[1] = ts_x + ox; cz[1] = ts_z + oz;
				cx[2] = te_x + ix; cz[2] = te_z + iz;
				cx[3] = te_x + ox; cz[3] = te_z + oz;
				mnx = cx[0]; mxx = cx[0]; mnz = cz[0]; mxz = cz[0];
				for (int k = 1; k < 4; k++) begin
					if (cx[k] < mnx) mnx = cx[k];
					if (cx[k] > mxx) mxx = cx[k];
					if (cz[k] < mnz) mnz = cz[k];
					if (cz[k] > mxz) mxz = cz[k];
				end
				b[n].box_min_x = clamp32(mnx);
				b[n].box_min_z = clamp32(mnz);
				b[n].box_max_x = clamp32(mxx);
				b[n].box_max_z = clamp32(mxz);
				b[n].shelf_side = side[0];
				b[n].last_box = 1'b0;
				n++;
			end
		end
		if (n > 0)
			b[n - 1].last_box = 1'b1;
		return n;
	endfunction

	// predict on every accepted segment word, check every accepted box word
	always @(posedge clk) begin
		box_t pb[2];
		box_t want_box;
		int cnt;
		if (seg_valid && seg_ready) begin
			cnt = strip_boxes(seg, pb);
			for (int i = 0; i < cnt; i++)
				boxes_due.push_back(pb[i]);
		end
		if (box_valid && box_ready) begin
			if (boxes_due.size() == 0) begin
				report("unexpected box", 0, 0);
			end else begin
				want_box = boxes_due.pop_front();
				if (box.box_min_x !== want_box.box_min_x)
					report("box_min_x", box.box_min_x, want_box.box_min_x);
				if (box.box_min_z !== want_box.box_min_z)
					report("box_min_z", box.box_min_z, want_box.box_min_z);
				if (box.box_max_x !== want_box.box_max_x)
					report("box_max_x", box.box_max_x, want_box.box_max_x);
				if (box.box_max_z !== want_box.box_max_z)
					report("box_max_z", box.box_max_z, want_box.box_max_z);
				if (box.shelf_side !== want_box.shelf_side)
					report("shelf_side", box.shelf_side, want_box.shelf_side);
				if (box.last_box !== want_box.last_box)
					report("last_box", box.last_box, want_box.last_box);
			end
		end
	end

	// receiver side
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				box_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = quiet ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				box_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			box_ready <= 1'b1;
			do @(posedge clk); while (!box_valid);
		end
	end

	function automatic seg_t mk(input longint sx, input longint sz, input longint ex,
			input longint ez, input longint w, input longint l, input longint r);
		seg_t s;
		s.start_x = sx[31:0];
		s.start_z = sz[31:0];
		s.end_x = ex[31:0];
		s.end_z = ez[31:0];
		s.aisle_width = w[21:0];
		s.left_protrusion = l[21:0];
		s.right_protrusion = r[21:0];
		return s;
	endfunction

	function automatic logic [21:0] pick_protrusion();
		case ($urandom_range(0, 5))
			0: return 22'(thr_q) - 22'(thr_q != 0);
			1: return 22'(thr_q);
			2: return 22'(thr_q) + 22'd1;
			3: return 22'($urandom_range(0, 22'h3fffff));
			default: return 22'(thr_q + $urandom_range(1, 200000));
		endcase
	endfunction

	function automatic seg_t random_seg();
		seg_t s;
		longint sx, sz, dx, dz, span;
		int kind;
		kind = $urandom_range(0, 19);
		s = mk(0, 0, 0, 0, $urandom_range(0, 300000), pick_protrusion(), pick_protrusion());
		if (kind < 2) begin
			s = {$urandom, $urandom, $urandom, $urandom, 22'($urandom),
				22'($urandom), 22'($urandom)};
			return s;
		end
		if (kind < 4)
			s.aisle_width = 22'($urandom_range(0, 22'h3fffff));
		sx = longint'(signed'($urandom)) >>> $urandom_range(6, 10);
		sz = longint'(signed'($urandom)) >>> $urandom_range(6, 10);
		if (kind < 6) begin
			// short segment
			dx = longint'($urandom_range(0, 1200)) - 600;
			dz = longint'($urandom_range(0, 1200)) - 600;
		end else if (kind < 9) begin
			// right at the trim limit along one axis
			dx = 2 * longint'(trim_q) + ExtraLen + longint'($urandom_range(0, 4)) - 2;
			dz = 0;
			if ($urandom_range(0, 1)) begin
				dz = dx;
				dx = 0;
			end
			if ($urandom_range(0, 1)) dx = -dx;
			if ($urandom_range(0, 1)) dz = -dz;
		end else begin
			span = longint'(1) << $urandom_range(10, 25);
			dx = longint'($urandom_range(0, span[31:0])) - span / 2;
			dz = longint'($urandom_range(0, span[31:0])) - span / 2;
			if (trim_q > 22'h100000 && $urandom_range(0, 1))
				dx = dx * 8;
		end
		s.start_x = sx[31:0];
		s.start_z = sz[31:0];
		s.end_x = 32'(sx + dx);
		s.end_z = 32'(sz + dz);
		return s;
	endfunction

	task automatic send(input seg_t s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			seg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg <= s;
		seg_valid <= 1'b1;
		do @(posedge clk); while (!seg_ready);
	endtask

	task automatic drain();
		seg_valid <= 1'b0;
		do @(posedge clk); while (boxes_due.size() != 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_regs(input logic [21:0] d, input logic [21:0] t, input logic [15:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEPTH;
		cfg_data <= d;
		@(posedge clk);
		cfg_index <= REG_TRIM;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= REG_THR;
		cfg_data <= {6'd0, h};
		@(posedge clk);
		cfg_we <= 1'b0;
		depth_q = d;
		trim_q = t;
		thr_q = h;
	endtask

	initial begin
		seg_row_t table_rows[$];
		box_t pb[2];
		logic [21:0] pd[5], pt[5];
		logic [15:0] ph[5];
		longint lim;
		lim = 2 * 65536 + 6554;
		table_rows.push_back('{mk(0, 0, 4000000, 0, 100000, 0, 654), 1});
		table_rows.push_back('{mk(1000, 1000, 1000, 1000, 100000, 90000, 90000), 1});
		table_rows.push_back('{mk(0, 0, 654, 0, 100000, 90000, 0), 1});
		table_rows.push_back('{mk(0, 0, lim, 0, 100000, 90000, 90000), 1});
		table_rows.push_back('{mk(0, 0, lim + 1, 0, 100000, 90000, 0), 0});
		table_rows.push_back('{mk(0, 0, 0, lim + 1, 100000, 0, 90000), 0});
		table_rows.push_back('{mk(-500000, 300000, 800000, -900000, 131072, 700, 700), 0});
		table_rows.push_back('{mk(100, 200, 900000, 900000, 65536, 655, 656), 0});
		table_rows.push_back('{mk(-2147483648, -2147483648, 2147483647, 2147483647,
			22'h3fffff, 22'h3fffff, 22'h3fffff), 0});
		table_rows.push_back('{mk(2147483647, -2147483648, -2147483648, 2147483647,
			22'h3fffff, 22'h3fffff, 22'h3fffff), 0});
		table_rows.push_back('{mk(2147483647, 2147483647, 2147483000, 2140000000,
			200000, 22'h3fffff, 22'h3fffff), 0});
		table_rows.push_back('{mk(0, 0, -3000000, -1, 0, 1000, 1000), 0});
		table_rows.push_back('{mk(5, -5, 5, -3000005, 22'h3fffff, 0, 22'h3fffff), 0});
		pd = '{22'd19661, 22'd0, 22'h3fffff, 22'd100000, 22'd500};
		pt = '{22'd65536, 22'd0, 22'h3fffff, 22'd3000, 22'd200000};
		ph = '{16'd655, 16'd0, 16'hffff, 16'd30000, 16'd1};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i]) begin
			if (table_rows[i].no_box && strip_boxes(table_rows[i].s, pb) != 0)
				report("directed row gives boxes", i, 0);
			send(table_rows[i].s);
		end
		drain();
		for (int ph_i = 0; ph_i < 5; ph_i++) begin
			if (ph_i > 0)
				write_regs(pd[ph_i], pt[ph_i], ph[ph_i]);
			if (ph_i == 2)
				hold_req = 1'b1;
			for (int i = 0; i < 260; i++) begin
				if (i % 90 == 0)
					quiet = ($urandom_range(0, 2) == 0);
				if (ph_i == 3 && i == 130) begin
					seg_valid <= 1'b0;
					do @(posedge clk); while (boxes_due.size() != 0);
				end
				send(random_seg());
			end
			quiet = 1'b0;
			drain();
		end
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(12 * 600000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
